/* src/csp_pkg.sv */
`default_nettype none
package csp_pkg;

	localparam int MAX_STACK_DEPTH = 64;
	localparam int NUM_RECORDS     = 256;

	localparam int STK_AW = (MAX_STACK_DEPTH > 1) ? $clog2(MAX_STACK_DEPTH) : 1;
	localparam int REC_AW = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 288;

	localparam logic [1:0] STATUS_PUSHED   = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_RECORDED = 2'd2;
	localparam logic [1:0] STATUS_SKIPPED  = 2'd3;

	localparam logic CMD_ENTRY = 1'b0;
	localparam logic CMD_EXIT  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd1;
		logic rd2;
		logic rd3;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic long_path;
	} dp_sts_t;

	typedef struct packed {
		logic [63:0] calls;
		logic [63:0] total;
		logic [63:0] self_time;
	} rec_t;

endpackage
`default_nettype wire

/* src/call_stack_profiler_unit.sv */
// The result of an entry or a skipped exit is loaded into the output register in ST_DONE
// straight after acceptance, that of a recorded exit after ST_RD1, ST_RD2 and ST_RD3, the
// stack and record memory read, subtract and accumulate steps; ST_DONE waits while a result
// is stalled. A new transaction is accepted the cycle after the result is loaded.
// Reset clears the depth, the overflow count and the record valid bits and sets
// count_source to 1; the stack memories are not cleared.
`default_nettype none
module call_stack_profiler_unit
	import csp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // function_index, cycle_stamp, instr_stamp
	input  wire logic                  s_tuser,   // cmd
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // depth_now, overflow_total, calls_now,
	                                              // total_now, self_now
	output logic [1:0]                 m_tuser    // status
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	csp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

/* src/csp_ctrl.sv */
`default_nettype none
module csp_ctrl
	import csp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.long_path ? ST_RD1 : ST_DONE;
				end
			end
			ST_RD1: state_d = ST_RD2;
			ST_RD2: state_d = ST_RD3;
			ST_RD3: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_RD1: cmd.rd1 = 1'b1;
			ST_RD2: cmd.rd2 = 1'b1;
			ST_RD3: cmd.rd3 = 1'b1;
			ST_DONE: cmd.load_out = !out_vld_q || m_tready;
			default: cmd = '0;
		endcase
	end

	assign m_tvalid = out_vld_q;

endmodule
`default_nettype wire

/* src/csp_datapath.sv */
`default_nettype none
module csp_datapath
	import csp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_data,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                 m_tuser,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts
);

	logic [31:0]            depth_q;
	logic [63:0]            overflows_q;
	logic                   cs_q;
	logic [NUM_RECORDS-1:0] rec_vld_q;

	logic [63:0] stamp_mem [MAX_STACK_DEPTH];
	logic [63:0] child_mem [MAX_STACK_DEPTH];
	rec_t        rec_mem   [NUM_RECORDS];

	logic [7:0]        in_idx;
	logic [63:0]       in_stamp;
	logic [31:0]       d_exit;
	logic              ent_ovf;
	logic              ex_in;
	logic              push;
	logic [STK_AW-1:0] push_addr;
	logic [STK_AW-1:0] pop_addr;
	logic [STK_AW-1:0] caller_addr;
	logic [REC_AW-1:0] in_rec_addr;
	logic              in_idx_ok;

	logic [63:0]       stamp_s1;
	logic [1:0]        status_s1;
	logic [REC_AW-1:0] rec_addr_s1;
	logic              rec_flag_s1;
	logic              has_caller_s1;
	logic [STK_AW-1:0] caller_addr_s1;
	logic              rec_hit_s1;

	logic [63:0] stamp_rd_q;
	logic [63:0] child_rd_q;
	logic [63:0] caller_rd_q;
	rec_t        rec_rd_q;
	rec_t        rec_cur;

	logic [63:0] elapsed_q;
	logic [63:0] own_q;
	logic [63:0] calls_q;
	logic [63:0] total_q;
	logic [63:0] self_q;

	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	assign in_idx      = s_tdata[7:0];
	assign in_stamp    = cs_q ? s_tdata[71:8] : s_tdata[135:72];
	assign d_exit      = depth_q - 32'd1;
	assign ent_ovf     = depth_q >= 32'(MAX_STACK_DEPTH);
	assign ex_in       = d_exit < 32'(MAX_STACK_DEPTH);
	assign push        = cmd.accept && (s_tuser == CMD_ENTRY) && !ent_ovf;
	assign push_addr   = STK_AW'(depth_q);
	assign pop_addr    = STK_AW'(d_exit);
	assign caller_addr = STK_AW'(d_exit - 32'd1);
	assign in_rec_addr = REC_AW'(in_idx);
	assign in_idx_ok   = 32'(in_idx) < 32'(NUM_RECORDS);

	assign sts.long_path = (s_tuser == CMD_EXIT) && ex_in;

	assign rec_cur = rec_hit_s1 ? rec_rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			overflows_q <= '0;
			cs_q        <= 1'b1;
			rec_vld_q   <= '0;
		end else begin
			if (cfg_valid) begin
				cs_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (s_tuser == CMD_ENTRY) begin
					depth_q <= depth_q + 32'd1;
					if (ent_ovf) begin
						overflows_q <= overflows_q + 64'd1;
					end
				end else begin
					depth_q <= d_exit;
				end
			end
			if (cmd.rd3 && rec_flag_s1) begin
				rec_vld_q[rec_addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stamp_mem[push_addr] <= in_stamp;
		end
		if (cmd.accept) begin
			stamp_rd_q <= stamp_mem[pop_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			child_mem[push_addr] <= '0;
		end else if (cmd.rd2 && has_caller_s1) begin
			child_mem[caller_addr_s1] <= caller_rd_q + elapsed_q;
		end
		if (cmd.accept) begin
			child_rd_q  <= child_mem[pop_addr];
			caller_rd_q <= child_mem[caller_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd3 && rec_flag_s1) begin
			rec_mem[rec_addr_s1] <= '{calls: calls_q, total: total_q,
				self_time: rec_cur.self_time + own_q};
		end
		if (cmd.accept) begin
			rec_rd_q <= rec_mem[in_rec_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			stamp_s1       <= in_stamp;
			rec_addr_s1    <= in_rec_addr;
			rec_hit_s1     <= rec_vld_q[in_rec_addr];
			rec_flag_s1    <= (s_tuser == CMD_EXIT) && ex_in && in_idx_ok;
			has_caller_s1  <= d_exit != 32'd0;
			caller_addr_s1 <= caller_addr;
			if (s_tuser == CMD_ENTRY) begin
				status_s1 <= ent_ovf ? STATUS_OVERFLOW : STATUS_PUSHED;
			end else begin
				status_s1 <= ex_in ? STATUS_RECORDED : STATUS_SKIPPED;
			end
		end
		if (cmd.rd1) begin
			elapsed_q <= stamp_s1 - stamp_rd_q;
			calls_q   <= rec_cur.calls + 64'd1;
		end
		if (cmd.rd2) begin
			own_q   <= elapsed_q - child_rd_q;
			total_q <= rec_cur.total + elapsed_q;
		end
		if (cmd.rd3) begin
			self_q <= rec_cur.self_time + own_q;
		end
		if (cmd.load_out) begin
			m_tuser_q <= status_s1;
			if (rec_flag_s1) begin
				m_tdata_q <= {self_q, total_q, calls_q, overflows_q, depth_q};
			end else begin
				m_tdata_q <= {192'd0, overflows_q, depth_q};
			end
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
`default_nettype wire

/* src/csp_checker.sv */
`default_nettype none
module csp_checker
	import csp_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [1:0]            m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result transaction changed.");

	a_zero_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STATUS_RECORDED) |-> m_tdata[287:96] == 192'd0)
		else $error("Record fields nonzero on a transaction that is not a recorded exit.");

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STATUS_PUSHED) |->
		(m_tdata[31:0] != 32'd0) && (m_tdata[31:0] <= 32'(MAX_STACK_DEPTH)))
		else $error("Push reported with depth out of range.");

	a_ovf_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STATUS_OVERFLOW) |->
		(m_tdata[31:0] > 32'(MAX_STACK_DEPTH)) || (m_tdata[31:0] == 32'd0))
		else $error("Overflow reported with depth inside the stack.");

	a_rec_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STATUS_RECORDED) |-> m_tdata[31:0] < 32'(MAX_STACK_DEPTH))
		else $error("Recorded exit reported with depth out of range.");

endmodule

bind call_stack_profiler_unit csp_checker u_csp_checker (.*);
`default_nettype wire

/* tb/sv/call_stack_profiler_unit_tb.sv */
module call_stack_profiler_unit_tb;
	import csp_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] depth;
		logic [63:0] overflows;
		logic [63:0] calls;
		logic [63:0] total;
		logic [63:0] self_time;
	} profile_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // function_index, cycle_stamp, instr_stamp
	logic                  s_tuser;   // cmd
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // depth_now, overflow_total, calls_now, total_now, self_now
	logic [1:0]            m_tuser;   // status

	logic        count_source;
	logic [31:0] shadow_depth;
	logic [63:0] overflow_count;
	logic [63:0] frame_stamp [MAX_STACK_DEPTH];
	logic [63:0] frame_child [MAX_STACK_DEPTH];
	bit          frame_valid [MAX_STACK_DEPTH];
	logic [63:0] rec_calls [NUM_RECORDS];
	logic [63:0] rec_total [NUM_RECORDS];
	logic [63:0] rec_self [NUM_RECORDS];

	profile_result_t pending_results [$];
	int          err_count;
	int          src_idle_pct;
	int          snk_idle_pct;
	int          entry_bias;
	logic [63:0] cycle_clock;
	logic [63:0] instr_clock;

	call_stack_profiler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic profile_result_t profile_event(logic cmd, logic [7:0] idx,
			logic [63:0] cyc, logic [63:0] ins);
		profile_result_t r;
		logic [63:0] stamp;
		logic [63:0] elapsed;
		logic [63:0] own;
		logic [31:0] d;
		r = '{default: '0};
		stamp = count_source ? cyc : ins;
		if (cmd == CMD_ENTRY) begin
			d = shadow_depth;
			shadow_depth = shadow_depth + 32'd1;
			if (d >= MAX_STACK_DEPTH) begin
				overflow_count = overflow_count + 64'd1;
				r.status = STATUS_OVERFLOW;
			end else begin
				frame_stamp[d] = stamp;
				frame_child[d] = '0;
				frame_valid[d] = 1'b1;
				r.status = STATUS_PUSHED;
			end
		end else begin
			d = shadow_depth - 32'd1;
			shadow_depth = d;
			if (d >= MAX_STACK_DEPTH) begin
				r.status = STATUS_SKIPPED;
			end else begin
				elapsed = stamp - frame_stamp[d];
				own = elapsed - frame_child[d];
				if (32'(idx) < NUM_RECORDS) begin
					rec_calls[idx] = rec_calls[idx] + 64'd1;
					rec_total[idx] = rec_total[idx] + elapsed;
					rec_self[idx] = rec_self[idx] + own;
					r.calls = rec_calls[idx];
					r.total = rec_total[idx];
					r.self_time = rec_self[idx];
				end
				if (d != 0)
					frame_child[d - 1] = frame_child[d - 1] + elapsed;
				r.status = STATUS_RECORDED;
			end
		end
		r.depth = shadow_depth;
		r.overflows = overflow_count;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch in %s at %0t: got %h, expected %h", field, $realtime, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin
		profile_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result status", 64'(m_tuser), '0);
			end else begin
				e = pending_results.pop_front();
				if (m_tuser !== e.status)
					report_mismatch("status", 64'(m_tuser), 64'(e.status));
				if (m_tdata[31:0] !== e.depth)
					report_mismatch("depth_now", 64'(m_tdata[31:0]), 64'(e.depth));
				if (m_tdata[95:32] !== e.overflows)
					report_mismatch("overflow_total", m_tdata[95:32], e.overflows);
				if (m_tdata[159:96] !== e.calls)
					report_mismatch("calls_now", m_tdata[159:96], e.calls);
				if (m_tdata[223:160] !== e.total)
					report_mismatch("total_now", m_tdata[223:160], e.total);
				if (m_tdata[287:224] !== e.self_time)
					report_mismatch("self_now", m_tdata[287:224], e.self_time);
			end
		end
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic send_event(logic cmd, logic [7:0] idx, logic [63:0] cyc, logic [63:0] ins);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {ins, cyc, idx};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(profile_event(cmd, idx, cyc, ins));
	endtask

	task automatic stop_source();
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count_source(logic value);
		stop_source();
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_source = value;
	endtask

	function automatic logic pick_cmd();
		int pct;
		if (shadow_depth == 0 || shadow_depth[31])
			pct = 100;
		else if (shadow_depth >= MAX_STACK_DEPTH)
			pct = 35;
		else
			pct = entry_bias;
		return ($urandom_range(99) < pct) ? CMD_ENTRY : CMD_EXIT;
	endfunction

	// An exit must never pop a frame that was not pushed since reset.
	task automatic send_timed(logic cmd);
		logic [7:0]  idx;
		logic [31:0] d;
		d = shadow_depth - 32'd1;
		if (cmd == CMD_EXIT && d < MAX_STACK_DEPTH && !frame_valid[d])
			cmd = CMD_ENTRY;
		idx = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
		cycle_clock = cycle_clock + 64'($urandom_range(400));
		instr_clock = instr_clock + 64'($urandom_range(150));
		if ($urandom_range(99) < 8)
			send_event(cmd, idx, {$urandom, $urandom}, {$urandom, $urandom});
		else
			send_event(cmd, idx, cycle_clock, instr_clock);
	endtask

	task automatic test_directed();
		send_event(CMD_EXIT, 8'd0, 64'd10, 64'd10);
		send_event(CMD_ENTRY, 8'd0, 64'd20, 64'd20);
		send_event(CMD_ENTRY, 8'd0, 64'd0, 64'd5);
		send_event(CMD_ENTRY, 8'd0, 64'd100, 64'd6);
		send_event(CMD_EXIT, 8'd255, 64'd350, 64'd7);
		send_event(CMD_EXIT, 8'd0, 64'd1000, 64'd8);
		send_event(CMD_ENTRY, 8'd255, '1, 64'd9);
		send_event(CMD_EXIT, 8'd255, 64'd5, 64'd10);
		write_count_source(1'b0);
		send_event(CMD_ENTRY, 8'd17, '1, 64'd0);
		send_event(CMD_ENTRY, 8'd0, '1, 64'h8000_0000_0000_0000);
		send_event(CMD_EXIT, 8'd128, 64'd0, '1);
		send_event(CMD_EXIT, 8'd1, 64'd0, 64'd3);
		send_event(CMD_EXIT, 8'd1, '1, '1);
		send_event(CMD_ENTRY, 8'd1, '1, '1);
		write_count_source(1'b1);
	endtask

	task automatic test_stack_limit();
		while (shadow_depth != MAX_STACK_DEPTH + 2)
			send_timed(CMD_ENTRY);
		while (shadow_depth != 0)
			send_timed(CMD_EXIT);
	endtask

	task automatic test_random_traffic(int n);
		cycle_clock = {$urandom, $urandom};
		instr_clock = {$urandom, $urandom};
		repeat (n)
			send_timed(pick_cmd());
	endtask

	task automatic test_pressure();
		repeat (12)
			send_timed(pick_cmd());
		stop_source();
		drain();
		repeat (12)
			send_timed(pick_cmd());
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		count_source = 1'b1;
		shadow_depth = '0;
		overflow_count = '0;
		err_count = 0;
		for (int i = 0; i < MAX_STACK_DEPTH; i++) begin
			frame_stamp[i] = '0;
			frame_child[i] = '0;
			frame_valid[i] = 1'b0;
		end
		for (int i = 0; i < NUM_RECORDS; i++) begin
			rec_calls[i] = '0;
			rec_total[i] = '0;
			rec_self[i] = '0;
		end
		cycle_clock = '0;
		instr_clock = '0;
		src_idle_pct = 7;
		snk_idle_pct = 80;
		entry_bias = 48;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_stack_limit();
		test_random_traffic(550);

		write_count_source(1'b0);
		src_idle_pct = 80;
		snk_idle_pct = 7;
		entry_bias = 53;
		test_random_traffic(550);

		write_count_source(1'b1);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		entry_bias = 50;
		test_random_traffic(480);
		test_pressure();

		stop_source();
		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("call_stack_profiler_unit verification clean");
		end else begin
			$display("call_stack_profiler_unit verification failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("call_stack_profiler_unit verification failed");
		$finish;
	end

endmodule

/* sim.f */
src/csp_pkg.sv
src/csp_ctrl.sv
src/csp_datapath.sv
src/call_stack_profiler_unit.sv
src/csp_checker.sv
tb/sv/call_stack_profiler_unit_tb.sv
